### src/crcpc_pkg.sv
// ----------------------------------------------------------------------------
// crcpc_pkg - shared types and constants of the CRC polynomial checker
// Register codes, reset values, the per-cell record and the CRC step function.
// ----------------------------------------------------------------------------
`default_nettype none

package crcpc_pkg;

  localparam int unsigned MAX_STEPS_DEF   = 64;
  localparam int unsigned CHECK_STEPS_DEF = 8;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned MASK_W  = 64;
  localparam int unsigned DIST_W  = 7;
  localparam int unsigned CNT_W   = 8;   // forward plus reverse matches, at most 128
  localparam int unsigned HITS_W  = 9;
  localparam int unsigned INDEX_W = 3;

  // register indexes
  localparam logic [INDEX_W-1:0] REG_FIRST_START   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_FIRST_TARGET  = 3'd1;
  localparam logic [INDEX_W-1:0] REG_SECOND_START  = 3'd2;
  localparam logic [INDEX_W-1:0] REG_SECOND_TARGET = 3'd3;
  localparam logic [INDEX_W-1:0] REG_DIST_LIMIT    = 3'd4;

  localparam logic [WORD_W-1:0] TOP_BIT             = 32'h8000_0000;
  localparam logic [WORD_W-1:0] RST_FIRST_START     = 32'h03B1_590E;
  localparam logic [WORD_W-1:0] RST_FIRST_TARGET    = 32'h399C_BDF3;
  localparam logic [WORD_W-1:0] SECOND_START_DELTA  = 32'h7339_7BE6;
  localparam logic [WORD_W-1:0] RST_SECOND_START    = RST_FIRST_TARGET ^ SECOND_START_DELTA;
  localparam logic [WORD_W-1:0] RST_SECOND_TARGET   = 32'hB5E0_5E20;
  localparam logic [DIST_W-1:0] RST_DIST_LIMIT      = 7'd64;

  typedef struct packed {
    logic [WORD_W-1:0] first_start;
    logic [WORD_W-1:0] first_target;
    logic [WORD_W-1:0] second_start;
    logic [WORD_W-1:0] second_target;
    logic [DIST_W-1:0] lim;          // distance limit already clamped
  } cfg_t;

  // one request as it travels down the chain
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] poly;
    logic [WORD_W-1:0] fwd_v;
    logic [WORD_W-1:0] rev_v;
    logic [WORD_W-1:0] sec_f_v;
    logic [WORD_W-1:0] sec_r_v;
    logic [MASK_W-1:0] fmask;
    logic [MASK_W-1:0] rmask;
    logic [CNT_W-1:0]  cnt;
    logic              sf_ok;
    logic              sr_ok;
  } stage_t;

  function automatic logic [WORD_W-1:0] crc_step(input logic [WORD_W-1:0] v,
                                                 input logic [WORD_W-1:0] p);
    logic [WORD_W-1:0] s;
    s = {v[WORD_W-2:0], 1'b0};
    return ((v & TOP_BIT) != '0) ? (s ^ p) : s;
  endfunction

endpackage

`default_nettype wire

### src/crc_poly_candidate_checker.sv
// ----------------------------------------------------------------------------
// crc_poly_candidate_checker - brute-force CRC-32 polynomial screening
// Tests one candidate polynomial per cycle, unless the chain stalls, against two shift constraints.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one candidate polynomial per request, tdata[31:0].
//   out_* : one result per candidate that scores at least one hit; candidates
//           without a hit are dropped inside the block.
//   cfg_* : register writes (start/target values, distance limit); write them
//           only while no candidate is in flight; the block does not enforce this.
// Path: a candidate passes a chain of max(MAX_STEPS, CHECK_STEPS) cells,
//   one CRC step per cell, then the output register.
// Throughput: one candidate per cycle while the chain advances; every cell takes a new request each
//   cycle that the chain advances.
// Stall: when the output register is full and out_tready is low, the whole
//   chain holds and in_tready drops; nothing is lost.
// Reset: all in-flight requests and the output are discarded and the
//   registers return to their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_poly_candidate_checker #(
  parameter int unsigned MAX_STEPS   = crcpc_pkg::MAX_STEPS_DEF,
  parameter int unsigned CHECK_STEPS = crcpc_pkg::CHECK_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [crcpc_pkg::INDEX_W-1:0]     cfg_index,
  input  logic [crcpc_pkg::WORD_W-1:0]      cfg_wdata,
  // candidates
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // [31:0] candidate_poly
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] hit_poly, [95:32] fwd_dist_mask, [159:96] rev_dist_mask,
  // [160] second_fwd_ok, [161] second_rev_ok, [170:162] hit_count, rest zero
  output logic [175:0]                      out_tdata
);
  import crcpc_pkg::*;

  localparam int unsigned CHAIN = (MAX_STEPS > CHECK_STEPS) ? MAX_STEPS : CHECK_STEPS;

  typedef struct packed {
    logic [WORD_W-1:0] poly;
    logic [MASK_W-1:0] fmask;
    logic [MASK_W-1:0] rmask;
    logic              sf_ok;
    logic              sr_ok;
    logic [HITS_W-1:0] hits;
  } result_t;

  // configuration registers
  logic [WORD_W-1:0] first_start_r;
  logic [WORD_W-1:0] first_target_r;
  logic [WORD_W-1:0] second_start_r;
  logic [WORD_W-1:0] second_target_r;
  logic [DIST_W-1:0] dist_limit_r;
  cfg_t              cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_start_r   <= RST_FIRST_START;
      first_target_r  <= RST_FIRST_TARGET;
      second_start_r  <= RST_SECOND_START;
      second_target_r <= RST_SECOND_TARGET;
      dist_limit_r    <= RST_DIST_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_START:   first_start_r   <= cfg_wdata;
        REG_FIRST_TARGET:  first_target_r  <= cfg_wdata;
        REG_SECOND_START:  second_start_r  <= cfg_wdata;
        REG_SECOND_TARGET: second_target_r <= cfg_wdata;
        REG_DIST_LIMIT:    dist_limit_r    <= cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.first_start   = first_start_r;
    cfg.first_target  = first_target_r;
    cfg.second_start  = second_start_r;
    cfg.second_target = second_target_r;
    cfg.lim = (dist_limit_r > DIST_W'(MAX_STEPS)) ? DIST_W'(MAX_STEPS) : dist_limit_r;
  end

  // chain
  logic    adv;
  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_r;
  result_t res;
  stage_t  stg [0:CHAIN];

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  always_comb begin
    stg[0]         = '0;
    stg[0].valid   = in_tvalid;
    stg[0].poly    = in_tdata;
    stg[0].fwd_v   = first_start_r;
    stg[0].rev_v   = first_target_r;
    stg[0].sec_f_v = second_start_r;
    stg[0].sec_r_v = second_target_r;
  end

  for (genvar k = 0; k < CHAIN; k++) begin : g_cell
    crcpc_cell #(
      .IDX         (k),
      .CHECK_STEPS (CHECK_STEPS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .cfg   (cfg),
      .stg_i (stg[k]),
      .stg_o (stg[k+1])
    );
  end

  // hit count: match count times number of second flags set (0, 1 or 2)
  always_comb begin
    res.poly  = stg[CHAIN].poly;
    res.fmask = stg[CHAIN].fmask;
    res.rmask = stg[CHAIN].rmask;
    res.sf_ok = stg[CHAIN].sf_ok;
    res.sr_ok = stg[CHAIN].sr_ok;
    if (stg[CHAIN].sf_ok && stg[CHAIN].sr_ok) begin
      res.hits = {stg[CHAIN].cnt, 1'b0};
    end else if (stg[CHAIN].sf_ok || stg[CHAIN].sr_ok) begin
      res.hits = {1'b0, stg[CHAIN].cnt};
    end else begin
      res.hits = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = stg[CHAIN].valid && (res.hits != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_r.hits, out_r.sr_ok, out_r.sf_ok,
                       out_r.rmask, out_r.fmask, out_r.poly};

  // checks
  a_hits_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.hits != '0))
    else $error("result presented with zero hit count");

  a_flag_set : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.sf_ok || out_r.sr_ok))
    else $error("result presented without a second-constraint flag");

  a_mask_set : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.fmask | out_r.rmask) != '0))
    else $error("result presented with empty distance masks");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && !out_tready))
    else $error("chain held without an output stall");

endmodule

`default_nettype wire

### src/crcpc_cell.sv
// ----------------------------------------------------------------------------
// crcpc_cell - one step of the checker chain
// Advances the four CRC values by one step, records a distance hit for the
// first constraint and, in the cell whose depth equals CHECK_STEPS, latches the second-constraint flags.
// ----------------------------------------------------------------------------
`default_nettype none

module crcpc_cell #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned CHECK_STEPS = crcpc_pkg::CHECK_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  crcpc_pkg::cfg_t   cfg,
  input  crcpc_pkg::stage_t stg_i,
  output crcpc_pkg::stage_t stg_o
);
  import crcpc_pkg::*;

  localparam logic [DIST_W-1:0] DIST     = DIST_W'(IDX + 1);
  localparam bit                IS_CHECK = (IDX + 1 == CHECK_STEPS);

  stage_t data_nxt;
  stage_t data_r;
  logic   valid_r;
  logic   fhit;
  logic   rhit;

  always_comb begin
    data_nxt         = stg_i;
    data_nxt.fwd_v   = crc_step(stg_i.fwd_v, stg_i.poly);
    data_nxt.rev_v   = crc_step(stg_i.rev_v, stg_i.poly);
    data_nxt.sec_f_v = crc_step(stg_i.sec_f_v, stg_i.poly);
    data_nxt.sec_r_v = crc_step(stg_i.sec_r_v, stg_i.poly);
    fhit = (DIST <= cfg.lim) && (data_nxt.fwd_v == cfg.first_target);
    rhit = (DIST <= cfg.lim) && (data_nxt.rev_v == cfg.first_start);
    data_nxt.fmask[IDX] = fhit;
    data_nxt.rmask[IDX] = rhit;
    data_nxt.cnt = stg_i.cnt + CNT_W'(fhit) + CNT_W'(rhit);
    if (IS_CHECK) begin
      data_nxt.sf_ok = (data_nxt.sec_f_v == cfg.second_target);
      data_nxt.sr_ok = (data_nxt.sec_r_v == cfg.second_start);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= stg_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  always_comb begin
    stg_o       = data_r;
    stg_o.valid = valid_r;
  end

endmodule

`default_nettype wire
